FILE: rtl/core/host_bridge_config_pam_control_assert.svh
// assertion macros for the host bridge configuration block
`ifndef HOST_BRIDGE_CONFIG_PAM_CONTROL_ASSERT_SVH
`define HOST_BRIDGE_CONFIG_PAM_CONTROL_ASSERT_SVH

// condition holds in the same cycle
`define HB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in host bridge config block");

// condition holds in the cycle after the antecedent
`define HB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in host bridge config block");

`endif

FILE: rtl/core/hbpam_pkg.sv
// package: codes, result type and reset table of the host bridge config space
package hbpam_pkg;

  // access codes
  localparam logic [1:0] OP_CFG_RD = 2'd0;
  localparam logic [1:0] OP_CFG_WR = 2'd1;
  localparam logic [1:0] OP_RST_RD = 2'd2;
  localparam logic [1:0] OP_RST_WR = 2'd3;

  // pam byte offsets and fixed byte values
  localparam logic [7:0] PAM0_ADDR = 8'h59;
  localparam logic [7:0] PAM6_ADDR = 8'h5F;
  localparam logic [7:0] PAM_HARD_VAL = 8'h0F;
  localparam logic [7:0] FF_BYTE = 8'hFF;

  // one result item without the shadow and last flags
  typedef struct packed {
    logic [7:0] read_data;
    logic       map_valid;
    logic [3:0] region_index;
    logic       read_internal;
    logic       write_internal;
    logic       cpu_reset;
    logic       hard_reset;
  } res_t;

  localparam res_t RES_ZERO = '0;

  // reset contents of the configuration space
  function automatic logic [7:0] cfg_default(input logic [7:0] addr);
    logic [7:0] val;
    case (addr)
      8'h00: val = 8'h86;
      8'h01: val = 8'h80;
      8'h02: val = 8'hA3;
      8'h03: val = 8'h04;
      8'h04: val = 8'h06;
      8'h07: val = 8'h02;
      8'h08: val = 8'h10;
      8'h0B: val = 8'h06;
      8'h50: val = 8'hA0;
      8'h52: val = 8'h44;
      8'h57: val = 8'h31;
      8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h66, 8'h67: val = 8'h02;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // identification offsets that ignore writes
  function automatic logic cfg_read_only(input logic [7:0] addr);
    return addr inside {[8'h00:8'h03], [8'h08:8'h0B], 8'h0E};
  endfunction

endpackage

FILE: rtl/core/host_bridge_config_pam_control.sv
// host bridge pci configuration space with pam attribute map and reset control
// an accepted item is decoded in ST_LOOK; each result goes to the output register from ST_EMIT once it is free
// a new item is not taken until the last result of the current one has left ST_EMIT;
//   a write with no result goes from ST_LOOK straight back to idle
// reset: per-byte valid bits clear at once so the store reads its default values,
//   no clearing pass; reset-control and shadow flag clear to zero
module host_bridge_config_pam_control (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [2:0] in_function_number,
  input  logic [7:0] in_reg_address,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_map_valid,
  output logic [3:0] out_region_index,
  output logic       out_read_internal,
  output logic       out_write_internal,
  output logic       out_shadow_bios,
  output logic       out_cpu_reset,
  output logic       out_hard_reset,
  output logic       out_last
);
  import hbpam_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // latched item
  logic [1:0] op_r;
  logic [2:0] func_r;
  logic [7:0] addr_r;
  logic [7:0] data_r;

  // configuration store, valid bits and small registers
  logic [7:0]   mem [256];
  logic [7:0]   mem_rdata_r;
  logic [7:0]   rd_addr_r;
  logic [255:0] vld_r;
  logic [7:0]   rst_ctl_r;
  logic         shadow_r;

  // pending results
  res_t       buf_r [2];
  res_t       buf0_nxt, buf1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       idx_r;

  // output register
  logic       out_valid_r;
  res_t       out_res_r;
  logic       out_shadow_r;
  logic       out_last_r;

  logic       accept;
  logic       mem_we;
  logic [7:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic [7:0] old_byte;
  logic [7:0] diff;
  logic [2:0] pam_n;
  logic       shadow_nxt;
  logic       has_a, has_b;
  res_t       res_a, res_b;
  logic       out_free;
  logic       emit_last;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign emit_last = idx_r || (cnt_r == 2'd1);

  // store read, issued when the item is accepted
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr_r   <= (in_opcode == OP_RST_WR) ? PAM0_ADDR : in_reg_address;
      mem_rdata_r <= mem[(in_opcode == OP_RST_WR) ? PAM0_ADDR : in_reg_address];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // stored byte, or its reset value when never written
  assign old_byte = vld_r[rd_addr_r] ? mem_rdata_r : cfg_default(rd_addr_r);

  // decode the item and build its results
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = addr_r;
    mem_wdata  = data_r;
    shadow_nxt = shadow_r;
    has_a      = 1'b0;
    has_b      = 1'b0;
    res_a      = RES_ZERO;
    res_b      = RES_ZERO;
    diff       = old_byte ^ data_r;
    pam_n      = 3'(addr_r - PAM0_ADDR);
    case (op_r)
      OP_CFG_RD: begin
        has_a           = 1'b1;
        res_a.read_data = (func_r != 3'd0) ? FF_BYTE : old_byte;
      end
      OP_CFG_WR: begin
        if ((func_r == 3'd0) && !cfg_read_only(addr_r)) begin
          mem_we = 1'b1;
          if (addr_r == PAM0_ADDR) begin
            if (diff[7:4] != 4'd0) begin
              has_b                = 1'b1;
              res_b.map_valid      = 1'b1;
              res_b.read_internal  = data_r[4];
              res_b.write_internal = data_r[5];
              shadow_nxt           = data_r[4];
            end
          end else if ((addr_r > PAM0_ADDR) && (addr_r <= PAM6_ADDR)) begin
            if (diff[3:0] != 4'd0) begin
              has_a                = 1'b1;
              res_a.map_valid      = 1'b1;
              res_a.region_index   = {pam_n, 1'b0} - 4'd1;
              res_a.read_internal  = data_r[0];
              res_a.write_internal = data_r[1];
            end
            if (diff[7:4] != 4'd0) begin
              has_b                = 1'b1;
              res_b.map_valid      = 1'b1;
              res_b.region_index   = {pam_n, 1'b0};
              res_b.read_internal  = data_r[4];
              res_b.write_internal = data_r[5];
            end
          end
        end
      end
      OP_RST_RD: begin
        has_a           = 1'b1;
        res_a.read_data = rst_ctl_r;
      end
      OP_RST_WR: begin
        if (data_r[2] && !rst_ctl_r[2]) begin
          // hard reset rewrites pam0 first
          if (data_r[1]) begin
            mem_we    = 1'b1;
            mem_waddr = PAM0_ADDR;
            mem_wdata = PAM_HARD_VAL;
            if (old_byte[7:4] != 4'd0) begin
              has_a           = 1'b1;
              res_a.map_valid = 1'b1;
              shadow_nxt      = 1'b0;
            end
          end
          has_b            = 1'b1;
          res_b.cpu_reset  = 1'b1;
          res_b.hard_reset = data_r[1];
        end
      end
      default: begin
        has_a = 1'b0;
      end
    endcase
    buf0_nxt = has_a ? res_a : res_b;
    buf1_nxt = res_b;
    cnt_nxt  = {1'b0, has_a} + {1'b0, has_b};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = (cnt_nxt == 2'd0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (out_free && emit_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      rst_ctl_r   <= 8'h00;
      shadow_r    <= 1'b0;
      cnt_r       <= 2'd0;
      idx_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOOK) begin
        cnt_r    <= cnt_nxt;
        idx_r    <= 1'b0;
        shadow_r <= shadow_nxt;
        if (mem_we) vld_r[mem_waddr] <= 1'b1;
        if (op_r == OP_RST_WR) rst_ctl_r <= data_r;
      end
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
        idx_r       <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      func_r <= in_function_number;
      addr_r <= in_reg_address;
      data_r <= in_write_data;
    end
    if (state_r == ST_LOOK) begin
      buf_r[0] <= buf0_nxt;
      buf_r[1] <= buf1_nxt;
    end
    if ((state_r == ST_EMIT) && out_free) begin
      out_res_r    <= buf_r[idx_r];
      out_shadow_r <= shadow_r;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_res_r.read_data;
  assign out_map_valid      = out_res_r.map_valid;
  assign out_region_index   = out_res_r.region_index;
  assign out_read_internal  = out_res_r.read_internal;
  assign out_write_internal = out_res_r.write_internal;
  assign out_shadow_bios    = out_shadow_r;
  assign out_cpu_reset      = out_res_r.cpu_reset;
  assign out_hard_reset     = out_res_r.hard_reset;
  assign out_last           = out_last_r;

`include "host_bridge_config_pam_control_assert.svh"

  `HB_ASSERT_NEXT(a_accept_look, accept, state_r == ST_LOOK)
  `HB_ASSERT_NOW(a_cpurst_last, out_valid_r && out_res_r.cpu_reset, out_last_r)
  `HB_ASSERT_NOW(a_hard_cpurst, out_valid_r && out_res_r.hard_reset, out_res_r.cpu_reset)
  `HB_ASSERT_NOW(a_region_range, out_valid_r && out_res_r.map_valid,
                 out_res_r.region_index <= 4'd12)
  `HB_ASSERT_NOW(a_emit_count, state_r == ST_EMIT, cnt_r != 2'd0)

endmodule
